FILE: hw/rtl/spbc_pkg.sv
// Shared types and constants for the soft power button controller.
`timescale 1ns / 1ps

package spbc_pkg;

  localparam int TIMER_BITS_DEF = 16;

  localparam logic [9:0]  DEBOUNCE_RESET   = 10'd30;
  localparam logic [15:0] LONG_PRESS_RESET = 16'd3000;
  localparam logic [15:0] TIMEOUT_RESET    = 16'd0;
  localparam logic [9:0]  DEB_MAX          = 10'd1023;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_TIMEOUT    = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    MODE_BOOT     = 3'd0,
    MODE_WAIT     = 3'd1,
    MODE_WAIT_DEB = 3'd2,
    MODE_RUN      = 3'd3,
    MODE_RELEASE  = 3'd4,
    MODE_OFF      = 3'd5,
    MODE_OFF_DEB  = 3'd6,
    MODE_TIMEOUT  = 3'd7
  } mode_t;

  typedef struct packed {
    logic [9:0]  debounce_ms;
    logic [15:0] shutdown_hold_ms;
    logic [15:0] press_timeout_ms;
  } cfg_t;

  typedef struct packed {
    mode_t mode_now;
    logic  shutdown_event;
    logic  reset_request;
    logic  hold_power;
  } result_t;

endpackage

FILE: hw/rtl/soft_power_button_controller_unit.sv
// Top level of the soft power button controller with input and result registers.
//
//   Channel  Direction  Handshake              Contents
//   s_axis   in         tvalid/tready          key sample and elapsed milliseconds
//   m_axis   out        tvalid/tready          hold, reset request, shutdown, mode
//   cfg      in         cfg_wr_en              debounce, long press, press timeout
//
// An item passes through the input register and then the result register. The
// state update for an item happens as it moves from the input register to the
// result register, so one item is taken every cycle unless the output stalls.
// Reset is synchronous and returns the block to boot with the register defaults.
// A stall on the output holds the result register and then the input register;
// s_axis_tready drops only when both hold an item.
`timescale 1ns / 1ps

module soft_power_button_controller_unit
  import spbc_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [15:0]            s_axis_tdata,  // key_pressed, elapsed_ms, zero fill
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [7:0]             m_axis_tdata,  // hold_power, reset_request,
                                                // shutdown_event, mode_now, zero fill
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t       cfg;
  result_t    result;
  result_t    out_item;
  logic       in_valid;
  logic       in_key;
  logic [7:0] in_elapsed;
  logic       out_valid;
  logic       out_free;
  logic       advance;

  assign out_free      = !out_valid || m_axis_tready;
  assign advance       = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  spbc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  spbc_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .key_pressed (in_key),
    .elapsed_ms  (in_elapsed),
    .cfg         (cfg),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_key     <= s_axis_tdata[0];
      in_elapsed <= s_axis_tdata[8:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_item};

endmodule

FILE: hw/rtl/spbc_cfg.sv
// Configuration register file of the soft power button controller.
`timescale 1ns / 1ps

module spbc_cfg
  import spbc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms      <= DEBOUNCE_RESET;
      cfg.shutdown_hold_ms <= LONG_PRESS_RESET;
      cfg.press_timeout_ms <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      case (reg_index_t'(cfg_index))
        REG_DEBOUNCE:   cfg.debounce_ms      <= cfg_wdata[9:0];
        REG_LONG_PRESS: cfg.shutdown_hold_ms <= cfg_wdata;
        REG_TIMEOUT:    cfg.press_timeout_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/spbc_core.sv
// Mode, timer and latch state with the per-item update logic.
`timescale 1ns / 1ps

module spbc_core
  import spbc_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic       key_pressed,
  input  logic [7:0] elapsed_ms,
  input  cfg_t       cfg,
  output result_t    result
);

  localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  mode_t                 mode, mode_next;
  logic [9:0]            deb_timer, deb_timer_next;
  logic [TIMER_BITS-1:0] wait_timer, wait_timer_next;
  logic [TIMER_BITS-1:0] press_timer, press_timer_next;
  logic                  release_seen, release_seen_next;
  logic                  hold_level, hold_level_next;

  logic [7:0]            elapsed;
  logic [10:0]           deb_sum;
  logic [9:0]            deb_sat;
  logic                  deb_done;
  logic [TIMER_BITS:0]   wait_sum, press_sum;
  logic [TIMER_BITS-1:0] wait_sat, press_sat;
  logic                  wait_expired, press_long;
  logic                  reset_request, shutdown_event;

  // A sample that claims no time still counts as one millisecond.
  assign elapsed = (elapsed_ms == 8'd0) ? 8'd1 : elapsed_ms;

  assign deb_sum  = {1'b0, deb_timer} + {3'd0, elapsed};
  assign deb_sat  = deb_sum[10] ? DEB_MAX : deb_sum[9:0];
  assign deb_done = deb_sat >= cfg.debounce_ms;

  assign wait_sum  = {1'b0, wait_timer} + (TIMER_BITS+1)'(elapsed);
  assign wait_sat  = wait_sum[TIMER_BITS] ? TIMER_MAX : wait_sum[TIMER_BITS-1:0];
  assign press_sum = {1'b0, press_timer} + (TIMER_BITS+1)'(elapsed);
  assign press_sat = press_sum[TIMER_BITS] ? TIMER_MAX : press_sum[TIMER_BITS-1:0];

  assign wait_expired = CMP_W'(wait_timer) >= CMP_W'(cfg.press_timeout_ms);
  assign press_long   = CMP_W'(press_timer) >= CMP_W'(cfg.shutdown_hold_ms);

  always_comb begin
    mode_next         = mode;
    deb_timer_next    = deb_timer;
    wait_timer_next   = wait_timer;
    press_timer_next  = press_timer;
    release_seen_next = release_seen;
    hold_level_next   = hold_level;
    reset_request     = 1'b0;
    shutdown_event    = 1'b0;
    case (mode)
      MODE_BOOT: begin
        deb_timer_next = deb_sat;
        if (deb_done) begin
          deb_timer_next = 10'd0;
          if (key_pressed) begin
            hold_level_next = 1'b1;
            mode_next       = MODE_RUN;
          end else begin
            hold_level_next = 1'b0;
            wait_timer_next = '0;
            mode_next       = MODE_WAIT;
          end
        end
      end
      MODE_WAIT: begin
        if (key_pressed) begin
          deb_timer_next = 10'd0;
          mode_next      = MODE_WAIT_DEB;
        end else if (cfg.press_timeout_ms != 16'd0 && wait_expired) begin
          hold_level_next = 1'b0;
          mode_next       = MODE_TIMEOUT;
        end else if (cfg.press_timeout_ms != 16'd0) begin
          wait_timer_next = wait_sat;
        end
      end
      MODE_WAIT_DEB: begin
        deb_timer_next = deb_sat;
        if (deb_done) begin
          deb_timer_next = 10'd0;
          if (key_pressed) begin
            hold_level_next = 1'b1;
            mode_next       = MODE_RUN;
          end else begin
            mode_next = MODE_WAIT;
          end
        end
      end
      MODE_RUN: begin
        if (!key_pressed) begin
          release_seen_next = 1'b1;
          press_timer_next  = '0;
        end else if (release_seen) begin
          if (press_long) begin
            hold_level_next = 1'b0;
            shutdown_event  = 1'b1;
            mode_next       = MODE_RELEASE;
          end else begin
            press_timer_next = press_sat;
          end
        end
      end
      MODE_RELEASE: begin
        if (!key_pressed) begin
          mode_next = MODE_OFF;
        end
      end
      MODE_OFF: begin
        if (key_pressed) begin
          deb_timer_next = 10'd0;
          mode_next      = MODE_OFF_DEB;
        end
      end
      MODE_OFF_DEB: begin
        deb_timer_next = deb_sat;
        if (deb_done) begin
          deb_timer_next = 10'd0;
          if (key_pressed) begin
            hold_level_next   = 1'b1;
            reset_request     = 1'b1;
            wait_timer_next   = '0;
            press_timer_next  = '0;
            release_seen_next = 1'b0;
            mode_next         = MODE_BOOT;
          end else begin
            mode_next = MODE_OFF;
          end
        end
      end
      default: begin
        hold_level_next = 1'b0;
        mode_next       = MODE_TIMEOUT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_BOOT;
      deb_timer    <= 10'd0;
      wait_timer   <= '0;
      press_timer  <= '0;
      release_seen <= 1'b0;
      hold_level   <= 1'b0;
    end else if (step) begin
      mode         <= mode_next;
      deb_timer    <= deb_timer_next;
      wait_timer   <= wait_timer_next;
      press_timer  <= press_timer_next;
      release_seen <= release_seen_next;
      hold_level   <= hold_level_next;
    end
  end

  assign result.hold_power     = hold_level_next;
  assign result.reset_request  = reset_request;
  assign result.shutdown_event = shutdown_event;
  assign result.mode_now       = mode_next;

endmodule
